[rtl/core/uoac_pkg.sv]
// ----------------------------------------------------------------------------
// uoac_pkg
// Shared types and constants for the ultrasonic obstacle avoidance controller.
// ----------------------------------------------------------------------------
package uoac_pkg;

  localparam int ECHO_COUNT_BITS_DEF = 16;
  localparam int TIMER_W             = 24;
  localparam int DIST_W              = 11;
  localparam int NEAR_W              = 10;
  localparam int DUTY_W              = 8;
  localparam int PHASE_W             = 4;
  localparam int APB_AW              = 5;
  localparam int APB_DW              = 32;

  localparam int CM_SCALE     = 1115;
  localparam int CM_SCALE_W   = 11;
  localparam int CM_SHIFT     = 16;
  localparam int FAR_LIMIT_CM = 400;
  // Smallest scaled echo count whose distance lies beyond the far limit.
  localparam int FAR_LIMIT_PROD = (FAR_LIMIT_CM + 1) << CM_SHIFT;
  localparam int FAR_PROD_W     = 26;

  localparam logic [DUTY_W-1:0]  DRIVE_SPEED_RST     = 8'd150;
  localparam logic [NEAR_W-1:0]  NEAR_CM_RST         = 10'd10;
  localparam logic [TIMER_W-1:0] TRIG_GAP_TICKS_RST  = 24'd20000;
  localparam logic [TIMER_W-1:0] TRIG_HIGH_TICKS_RST = 24'd12000;
  localparam logic [TIMER_W-1:0] STOP_TICKS_RST      = 24'd1000000;
  localparam logic [TIMER_W-1:0] REVERSE_TICKS_RST   = 24'd2000000;
  localparam logic [TIMER_W-1:0] TURN_TICKS_RST      = 24'd1000000;
  localparam logic [TIMER_W-1:0] PAUSE_TICKS_RST     = 24'd50000;

  typedef enum logic [PHASE_W-1:0] {
    PH_GAP1  = 4'd0,
    PH_TRIG  = 4'd1,
    PH_GAP2  = 4'd2,
    PH_WAIT  = 4'd3,
    PH_MEAS  = 4'd4,
    PH_STOP  = 4'd5,
    PH_REV   = 4'd6,
    PH_TURN  = 4'd7,
    PH_PAUSE = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    REG_DRIVE_SPEED     = 3'd0,
    REG_NEAR_CM         = 3'd1,
    REG_TRIG_GAP_TICKS  = 3'd2,
    REG_TRIG_HIGH_TICKS = 3'd3,
    REG_STOP_TICKS      = 3'd4,
    REG_REVERSE_TICKS   = 3'd5,
    REG_TURN_TICKS      = 3'd6,
    REG_PAUSE_TICKS     = 3'd7
  } reg_idx_t;

endpackage

[rtl/core/ultrasonic_obstacle_avoid_ctrl_top.sv]
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_avoid_ctrl_top
// Ultrasonic ranger sequencer with obstacle avoidance motor control.
// ----------------------------------------------------------------------------
// Each input beat carries one 1 us tick with the sampled echo level. Every
// accepted beat produces exactly one output beat that shows the trigger level,
// motor enable, directions, duties, latest distance, a distance strobe and the
// current phase after that tick.
// An accepted beat is registered and shown as an output beat from the next
// cycle on. One beat per cycle passes while out_ready stays high; the phase
// state and the output fields share one register set, and the echo width is
// kept as a running sum of 1115 per tick, so no multiplier is in the path.
// When the receiver stalls, the pending output beat is held and in_ready
// drops until it is taken; in_ready follows out_ready in the same cycle.
// The APB port writes the eight configuration registers at byte addresses
// 0, 4, ... 28; pready is always high. Write registers only while idle.
// Reset (synchronous, active high) restores the default configuration,
// starts in the first trigger gap with the motors disconnected and empties
// the output register.
// ----------------------------------------------------------------------------
module ultrasonic_obstacle_avoid_ctrl_top #(
  parameter int ECHO_COUNT_BITS = uoac_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          echo_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          trigger_out,
  output logic                          drive_enable,
  output logic                          dir_left,
  output logic                          dir_right,
  output logic [uoac_pkg::DUTY_W-1:0]   duty_left,
  output logic [uoac_pkg::DUTY_W-1:0]   duty_right,
  output logic [uoac_pkg::DIST_W-1:0]   distance_cm,
  output logic                          distance_valid,
  output logic [uoac_pkg::PHASE_W-1:0]  phase_now,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uoac_pkg::APB_AW-1:0]   paddr,
  input  logic [uoac_pkg::APB_DW-1:0]   pwdata,
  output logic [uoac_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import uoac_pkg::*;

  localparam int PROD_W = ECHO_COUNT_BITS + CM_SCALE_W;
  localparam int CMP_W  = (PROD_W > FAR_PROD_W) ? PROD_W : FAR_PROD_W;
  localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = {ECHO_COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [DUTY_W-1:0]  drive_speed;
  logic [NEAR_W-1:0]  near_cm;
  logic [TIMER_W-1:0] trig_gap_ticks;
  logic [TIMER_W-1:0] trig_high_ticks;
  logic [TIMER_W-1:0] stop_ticks;
  logic [TIMER_W-1:0] reverse_ticks;
  logic [TIMER_W-1:0] turn_ticks;
  logic [TIMER_W-1:0] pause_ticks;

  // Sequencer state.
  phase_t                 phase, phase_next;
  logic [TIMER_W-1:0]     phase_timer, phase_timer_next;
  logic [ECHO_COUNT_BITS-1:0] echo_ticks, echo_ticks_next;
  logic [PROD_W-1:0]      echo_prod, echo_prod_next;
  logic [DIST_W-1:0]      last_good_cm, last_good_cm_next;
  logic                   enable_reg, enable_reg_next;
  logic                   dir_left_reg, dir_left_reg_next;
  logic                   dir_right_reg, dir_right_reg_next;
  logic [DUTY_W-1:0]      duty_left_reg, duty_left_reg_next;
  logic [DUTY_W-1:0]      duty_right_reg, duty_right_reg_next;
  logic                   dist_strobe, dist_strobe_next;

  logic                   accept;
  logic                   cfg_write;
  reg_idx_t               cfg_idx;
  logic [TIMER_W-1:0]     timer_inc;
  logic [TIMER_W-1:0]     timer_lim;
  logic                   timer_done;
  logic [PROD_W-1:0]      cm_full;
  logic                   cm_in_range;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_speed     <= DRIVE_SPEED_RST;
      near_cm         <= NEAR_CM_RST;
      trig_gap_ticks  <= TRIG_GAP_TICKS_RST;
      trig_high_ticks <= TRIG_HIGH_TICKS_RST;
      stop_ticks      <= STOP_TICKS_RST;
      reverse_ticks   <= REVERSE_TICKS_RST;
      turn_ticks      <= TURN_TICKS_RST;
      pause_ticks     <= PAUSE_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_DRIVE_SPEED:     drive_speed     <= pwdata[DUTY_W-1:0];
        REG_NEAR_CM:         near_cm         <= pwdata[NEAR_W-1:0];
        REG_TRIG_GAP_TICKS:  trig_gap_ticks  <= pwdata[TIMER_W-1:0];
        REG_TRIG_HIGH_TICKS: trig_high_ticks <= pwdata[TIMER_W-1:0];
        REG_STOP_TICKS:      stop_ticks      <= pwdata[TIMER_W-1:0];
        REG_REVERSE_TICKS:   reverse_ticks   <= pwdata[TIMER_W-1:0];
        REG_TURN_TICKS:      turn_ticks      <= pwdata[TIMER_W-1:0];
        REG_PAUSE_TICKS:     pause_ticks     <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DRIVE_SPEED:     prdata = APB_DW'(drive_speed);
      REG_NEAR_CM:         prdata = APB_DW'(near_cm);
      REG_TRIG_GAP_TICKS:  prdata = APB_DW'(trig_gap_ticks);
      REG_TRIG_HIGH_TICKS: prdata = APB_DW'(trig_high_ticks);
      REG_STOP_TICKS:      prdata = APB_DW'(stop_ticks);
      REG_REVERSE_TICKS:   prdata = APB_DW'(reverse_ticks);
      REG_TURN_TICKS:      prdata = APB_DW'(turn_ticks);
      REG_PAUSE_TICKS:     prdata = APB_DW'(pause_ticks);
      default:             prdata = '0;
    endcase
  end

  // The state registers double as the output register.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (phase)
      PH_GAP1:  timer_lim = trig_gap_ticks;
      PH_TRIG:  timer_lim = trig_high_ticks;
      PH_GAP2:  timer_lim = trig_gap_ticks;
      PH_STOP:  timer_lim = stop_ticks;
      PH_REV:   timer_lim = reverse_ticks;
      PH_TURN:  timer_lim = turn_ticks;
      PH_PAUSE: timer_lim = pause_ticks;
      default:  timer_lim = '0;
    endcase
  end

  assign timer_inc  = phase_timer + TIMER_W'(1);
  assign timer_done = (timer_inc >= timer_lim) || (timer_lim == '0);

  assign cm_full     = echo_prod >> CM_SHIFT;
  assign cm_in_range = CMP_W'(echo_prod) < CMP_W'(FAR_LIMIT_PROD);

  always_comb begin
    phase_next          = phase;
    phase_timer_next    = phase_timer;
    echo_ticks_next     = echo_ticks;
    echo_prod_next      = echo_prod;
    last_good_cm_next   = last_good_cm;
    enable_reg_next     = enable_reg;
    dir_left_reg_next   = dir_left_reg;
    dir_right_reg_next  = dir_right_reg;
    duty_left_reg_next  = duty_left_reg;
    duty_right_reg_next = duty_right_reg;
    dist_strobe_next    = 1'b0;

    case (phase)
      PH_GAP1, PH_TRIG, PH_GAP2, PH_STOP, PH_REV, PH_TURN, PH_PAUSE: begin
        phase_timer_next = timer_done ? '0 : timer_inc;
        if (timer_done) begin
          case (phase)
            PH_GAP1: phase_next = PH_TRIG;
            PH_TRIG: phase_next = PH_GAP2;
            PH_GAP2: phase_next = PH_WAIT;
            PH_STOP: begin
              phase_next          = PH_REV;
              enable_reg_next     = 1'b1;
              dir_left_reg_next   = 1'b0;
              dir_right_reg_next  = 1'b0;
              duty_left_reg_next  = drive_speed;
              duty_right_reg_next = drive_speed;
            end
            PH_REV: begin
              phase_next          = PH_TURN;
              enable_reg_next     = 1'b1;
              dir_right_reg_next  = 1'b1;
              duty_right_reg_next = drive_speed;
            end
            PH_TURN: phase_next = PH_PAUSE;
            default: phase_next = PH_GAP1;
          endcase
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          echo_ticks_next = ECHO_COUNT_BITS'(1);
          echo_prod_next  = PROD_W'(CM_SCALE);
          phase_next      = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo_level) begin
          if (echo_ticks < ECHO_MAX) begin
            echo_ticks_next = echo_ticks + ECHO_COUNT_BITS'(1);
            echo_prod_next  = echo_prod + PROD_W'(CM_SCALE);
          end
        end else begin
          if (cm_in_range) begin
            last_good_cm_next = DIST_W'(cm_full);
          end
          dist_strobe_next = 1'b1;
          phase_timer_next = '0;
          if (last_good_cm_next >= DIST_W'(near_cm)) begin
            phase_next          = PH_PAUSE;
            enable_reg_next     = 1'b1;
            dir_left_reg_next   = 1'b1;
            dir_right_reg_next  = 1'b1;
            duty_left_reg_next  = drive_speed;
            duty_right_reg_next = drive_speed;
          end else begin
            phase_next      = PH_STOP;
            enable_reg_next = 1'b0;
          end
        end
      end
      default: begin
        phase_next       = PH_GAP1;
        phase_timer_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_GAP1;
      phase_timer    <= '0;
      echo_ticks     <= '0;
      echo_prod      <= '0;
      last_good_cm   <= '0;
      enable_reg     <= 1'b0;
      dir_left_reg   <= 1'b0;
      dir_right_reg  <= 1'b0;
      duty_left_reg  <= '0;
      duty_right_reg <= '0;
      dist_strobe    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        phase_timer    <= phase_timer_next;
        echo_ticks     <= echo_ticks_next;
        echo_prod      <= echo_prod_next;
        last_good_cm   <= last_good_cm_next;
        enable_reg     <= enable_reg_next;
        dir_left_reg   <= dir_left_reg_next;
        dir_right_reg  <= dir_right_reg_next;
        duty_left_reg  <= duty_left_reg_next;
        duty_right_reg <= duty_right_reg_next;
        dist_strobe    <= dist_strobe_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign trigger_out    = (phase == PH_TRIG);
  assign drive_enable   = enable_reg;
  assign dir_left       = dir_left_reg;
  assign dir_right      = dir_right_reg;
  assign duty_left      = duty_left_reg;
  assign duty_right     = duty_right_reg;
  assign distance_cm    = last_good_cm;
  assign distance_valid = dist_strobe;
  assign phase_now      = phase;

`ifndef SYNTH
  a_dist_limit: assert property (@(posedge clk) disable iff (rst)
    last_good_cm <= DIST_W'(FAR_LIMIT_CM))
    else $error("stored distance exceeds the far limit");

  a_strobe_phase: assert property (@(posedge clk) disable iff (rst)
    dist_strobe |-> (phase == PH_PAUSE || phase == PH_STOP))
    else $error("distance strobe outside the stop or pause phase");

  a_prod_track: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MEAS) |->
      (CMP_W'(echo_prod) == CMP_W'(echo_ticks) * CMP_W'(CM_SCALE)))
    else $error("scaled echo sum out of step with echo count");

  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no output beat");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(phase) && $stable(phase_timer)))
    else $error("sequencer advanced while the output was stalled");
`endif

endmodule

[bench/ultrasonic_obstacle_avoid_ctrl_top_test.sv]
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_avoid_ctrl_top_test
// Self-checking bench for the ultrasonic ranger and obstacle avoidance block.
// Echo ticks are streamed in over the valid/ready input and every output beat
// is compared with a cycle-free model of the phase sequencer, the distance
// conversion and the motor commands. Directed tests cover reset, timer limits,
// zero durations and speed changes during a maneuver; random measurement
// cycles under several configurations follow.
// ----------------------------------------------------------------------------
module ultrasonic_obstacle_avoid_ctrl_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uoac_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ECHO_MAX    = (1 << ECHO_COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic              trig;
    logic              en;
    logic              dir_l;
    logic              dir_r;
    logic [DUTY_W-1:0] duty_l;
    logic [DUTY_W-1:0] duty_r;
    logic [DIST_W-1:0] dist_cm;
    logic              dist_new;
    logic [PHASE_W-1:0] ph;
  } ranger_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               echo_level = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               trigger_out;
  logic               drive_enable;
  logic               dir_left;
  logic               dir_right;
  logic [DUTY_W-1:0]  duty_left;
  logic [DUTY_W-1:0]  duty_right;
  logic [DIST_W-1:0]  distance_cm;
  logic               distance_valid;
  logic [PHASE_W-1:0] phase_now;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  ultrasonic_obstacle_avoid_ctrl_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .echo_level     (echo_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .trigger_out    (trigger_out),
    .drive_enable   (drive_enable),
    .dir_left       (dir_left),
    .dir_right      (dir_right),
    .duty_left      (duty_left),
    .duty_right     (duty_right),
    .distance_cm    (distance_cm),
    .distance_valid (distance_valid),
    .phase_now      (phase_now),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Configuration mirror.
  logic [DUTY_W-1:0]  cfg_speed = DRIVE_SPEED_RST;
  logic [NEAR_W-1:0]  cfg_near  = NEAR_CM_RST;
  logic [TIMER_W-1:0] cfg_gap   = TRIG_GAP_TICKS_RST;
  logic [TIMER_W-1:0] cfg_high  = TRIG_HIGH_TICKS_RST;
  logic [TIMER_W-1:0] cfg_stop  = STOP_TICKS_RST;
  logic [TIMER_W-1:0] cfg_rev   = REVERSE_TICKS_RST;
  logic [TIMER_W-1:0] cfg_turn  = TURN_TICKS_RST;
  logic [TIMER_W-1:0] cfg_pause = PAUSE_TICKS_RST;

  // Sequencer state as the block should hold it.
  phase_t             mdl_phase  = PH_GAP1;
  logic [TIMER_W-1:0] mdl_timer  = '0;
  int                 mdl_echo   = 0;
  logic [DIST_W-1:0]  mdl_dist   = '0;
  logic               mdl_en     = 1'b0;
  logic               mdl_dl     = 1'b0;
  logic               mdl_dr     = 1'b0;
  logic [DUTY_W-1:0]  mdl_duty_l = '0;
  logic [DUTY_W-1:0]  mdl_duty_r = '0;

  reg_idx_t timer_regs[6] = '{REG_TRIG_GAP_TICKS, REG_TRIG_HIGH_TICKS, REG_STOP_TICKS,
                              REG_REVERSE_TICKS, REG_TURN_TICKS, REG_PAUSE_TICKS};

  ranger_beat_t pending_beats[$];
  ranger_beat_t want;
  ranger_beat_t got;
  bit idle_on = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int ticks_sent = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int decisions = 0;
  int obstacles = 0;
  int far_reads = 0;

  function automatic bit phase_elapsed(logic [TIMER_W-1:0] lim);
    mdl_timer = mdl_timer + 1'b1;
    if (mdl_timer >= lim || lim == '0) begin
      mdl_timer = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drive_motors(logic dl, logic dr);
    mdl_en     = 1'b1;
    mdl_dl     = dl;
    mdl_dr     = dr;
    mdl_duty_l = cfg_speed;
    mdl_duty_r = cfg_speed;
  endfunction

  function automatic ranger_beat_t ranger_step(logic echo);
    ranger_beat_t r;
    logic [63:0] cm;
    logic fresh;
    fresh = 1'b0;
    case (mdl_phase)
      PH_GAP1:  if (phase_elapsed(cfg_gap)) mdl_phase = PH_TRIG;
      PH_TRIG:  if (phase_elapsed(cfg_high)) mdl_phase = PH_GAP2;
      PH_GAP2:  if (phase_elapsed(cfg_gap)) mdl_phase = PH_WAIT;
      PH_WAIT: begin
        if (echo) begin
          mdl_echo  = 1;
          mdl_phase = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (mdl_echo < ECHO_MAX) mdl_echo++;
        end else begin
          cm = (64'(mdl_echo) * CM_SCALE) >> CM_SHIFT;
          if (cm <= FAR_LIMIT_CM) mdl_dist = cm[DIST_W-1:0];
          else far_reads++;
          fresh     = 1'b1;
          mdl_timer = '0;
          decisions++;
          if (mdl_dist >= cfg_near) begin
            drive_motors(1'b1, 1'b1);
            mdl_phase = PH_PAUSE;
          end else begin
            mdl_en    = 1'b0;
            mdl_phase = PH_STOP;
            obstacles++;
          end
        end
      end
      PH_STOP: begin
        if (phase_elapsed(cfg_stop)) begin
          drive_motors(1'b0, 1'b0);
          mdl_phase = PH_REV;
        end
      end
      PH_REV: begin
        if (phase_elapsed(cfg_rev)) begin
          mdl_en     = 1'b1;
          mdl_dr     = 1'b1;
          mdl_duty_r = cfg_speed;
          mdl_phase  = PH_TURN;
        end
      end
      PH_TURN:  if (phase_elapsed(cfg_turn)) mdl_phase = PH_PAUSE;
      PH_PAUSE: if (phase_elapsed(cfg_pause)) mdl_phase = PH_GAP1;
      default: begin
        mdl_phase = PH_GAP1;
        mdl_timer = '0;
      end
    endcase
    r.trig     = (mdl_phase == PH_TRIG);
    r.en       = mdl_en;
    r.dir_l    = mdl_dl;
    r.dir_r    = mdl_dr;
    r.duty_l   = mdl_duty_l;
    r.duty_r   = mdl_duty_r;
    r.dist_cm  = mdl_dist;
    r.dist_new = fresh;
    r.ph       = mdl_phase;
    return r;
  endfunction

  function automatic string beat_str(ranger_beat_t b);
    return $sformatf("trig=%0b en=%0b dir=%0b/%0b duty=%0d/%0d dist=%0d new=%0b phase=%0d",
                     b.trig, b.en, b.dir_l, b.dir_r, b.duty_l, b.duty_r, b.dist_cm,
                     b.dist_new, b.ph);
  endfunction

  // Echo level for stretches where no measurement is wanted.
  function automatic logic quiet_echo();
    if (mdl_phase == PH_WAIT || mdl_phase == PH_MEAS) return 1'b0;
    return 1'($urandom_range(0, 1));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ultrasonic_obstacle_avoid_ctrl_top_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {trigger_out, drive_enable, dir_left, dir_right, duty_left, duty_right,
             distance_cm, distance_valid, phase_now};
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Output beat with nothing expected: %s", beat_str(got));
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Beat %0d differs", beats_checked);
            $display("  expected %s", beat_str(want));
            $display("  actual   %s", beat_str(got));
          end
        end
      end
    end
  end

  task automatic send_tick(input logic echo);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    pending_beats.push_back(ranger_step(echo));
    ticks_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DRIVE_SPEED:     cfg_speed = data[DUTY_W-1:0];
      REG_NEAR_CM:         cfg_near  = data[NEAR_W-1:0];
      REG_TRIG_GAP_TICKS:  cfg_gap   = data[TIMER_W-1:0];
      REG_TRIG_HIGH_TICKS: cfg_high  = data[TIMER_W-1:0];
      REG_STOP_TICKS:      cfg_stop  = data[TIMER_W-1:0];
      REG_REVERSE_TICKS:   cfg_rev   = data[TIMER_W-1:0];
      REG_TURN_TICKS:      cfg_turn  = data[TIMER_W-1:0];
      REG_PAUSE_TICKS:     cfg_pause = data[TIMER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick(quiet_echo());
  endtask

  task automatic advance_to(input phase_t ph);
    while (mdl_phase != ph) send_tick(quiet_echo());
  endtask

  // The rise tick counts as one, so a pulse of width ticks ends in that count.
  task automatic measure(input int width);
    advance_to(PH_WAIT);
    repeat (width) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_reset_state();
    idle_on = 1'b1;
    run_ticks(6);
  endtask

  // Every timer is first held at its largest value, then cut below the
  // elapsed count so that the phase ends on the next tick.
  task automatic test_register_extremes();
    foreach (timer_regs[k]) cfg_write(timer_regs[k], 32'hFFFF_FFFF);
    cfg_write(REG_NEAR_CM, 32'd1023);
    cfg_write(REG_DRIVE_SPEED, 32'd0);
    run_ticks(20);
    cfg_write(REG_TRIG_GAP_TICKS, 32'd3);
    advance_to(PH_TRIG);
    run_ticks(20);
    cfg_write(REG_TRIG_HIGH_TICKS, 32'd2);
    measure(10);
    run_ticks(20);
    cfg_write(REG_STOP_TICKS, 32'd2);
    advance_to(PH_REV);
    run_ticks(20);
    cfg_write(REG_REVERSE_TICKS, 32'd2);
    advance_to(PH_TURN);
    run_ticks(20);
    cfg_write(REG_TURN_TICKS, 32'd2);
    advance_to(PH_PAUSE);
    run_ticks(20);
    cfg_write(REG_PAUSE_TICKS, 32'd2);
    advance_to(PH_GAP1);
  endtask

  task automatic test_zero_duration();
    foreach (timer_regs[k]) cfg_write(timer_regs[k], 32'd0);
    cfg_write(REG_NEAR_CM, 32'd0);
    cfg_write(REG_DRIVE_SPEED, 32'd255);
    measure(1);
    measure(3);
    cfg_write(REG_NEAR_CM, 32'd1);
    measure(58);
    measure(59);
    advance_to(PH_GAP1);
  endtask

  task automatic test_speed_change();
    foreach (timer_regs[k]) cfg_write(timer_regs[k], 32'd3);
    cfg_write(REG_DRIVE_SPEED, 32'd200);
    cfg_write(REG_NEAR_CM, 32'd1023);
    measure(5);
    send_tick(1'b1);
    cfg_write(REG_DRIVE_SPEED, 32'd255);
    advance_to(PH_REV);
    send_tick(1'b0);
    cfg_write(REG_DRIVE_SPEED, 32'd0);
    advance_to(PH_TURN);
    advance_to(PH_GAP1);
  endtask

  task automatic random_segment(input int count, input bit idling);
    int pulse_left;
    int w;
    logic echo;
    logic [APB_DW-1:0] junk;
    logic [NEAR_W-1:0] near;
    junk = $urandom();
    case ($urandom_range(0, 3))
      0:       cfg_write(REG_DRIVE_SPEED, {junk[31:DUTY_W], 8'd0});
      1:       cfg_write(REG_DRIVE_SPEED, {junk[31:DUTY_W], 8'd255});
      default: cfg_write(REG_DRIVE_SPEED, junk);
    endcase
    case ($urandom_range(0, 9))
      0:       near = '0;
      1:       near = '1;
      2:       near = NEAR_W'($urandom_range(0, 1023));
      default: near = NEAR_W'($urandom_range(0, 3));
    endcase
    junk = $urandom();
    cfg_write(REG_NEAR_CM, {junk[31:NEAR_W], near});
    foreach (timer_regs[k]) begin
      junk = $urandom();
      cfg_write(timer_regs[k], {junk[31:TIMER_W], TIMER_W'($urandom_range(0, 4))});
    end
    idle_on = idling;
    pulse_left = 0;
    repeat (count) begin
      if ($urandom_range(0, 199) == 0) settle();
      case (mdl_phase)
        PH_WAIT: begin
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: w = $urandom_range(1, 70);
              6, 7:             w = $urandom_range(55, 65);
              8:                w = $urandom_range(100, 400);
              default:          w = $urandom_range(1, 3);
            endcase
            pulse_left = w - 1;
            echo = 1'b1;
          end else begin
            echo = 1'b0;
          end
        end
        PH_MEAS: begin
          // An occasional early drop gives a cut-short echo.
          if (pulse_left > 0 && $urandom_range(0, 99) != 0) begin
            pulse_left--;
            echo = 1'b1;
          end else begin
            pulse_left = 0;
            echo = 1'b0;
          end
        end
        default: echo = 1'($urandom_range(0, 1));
      endcase
      send_tick(echo);
    end
  endtask

  task automatic test_random_traffic();
    int first_tick;
    int first_decision;
    first_tick = ticks_sent;
    first_decision = decisions;
    do begin
      random_segment(400, $urandom_range(0, 3) != 0);
    end while (ticks_sent - first_tick < 800 || decisions - first_decision < 15);
    random_segment(400, 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_register_extremes();
    test_zero_duration();
    test_speed_change();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d echo ticks and %0d checked beats with %0d mismatches.",
             ticks_sent, beats_checked, mismatches);
    $display("Distance decisions: %0d, obstacle maneuvers: %0d, beyond-range echoes: %0d.",
             decisions, obstacles, far_reads);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("ultrasonic_obstacle_avoid_ctrl_top_test passed");
    end else begin
      $display("ultrasonic_obstacle_avoid_ctrl_top_test failed");
    end
    $finish;
  end

endmodule
